@@ rtl/vertex_screen_projection_assert.svh @@
// assertion macros for the vertex screen projection checker
// expects clk and rst_n in the scope where a macro is used
`ifndef VERTEX_SCREEN_PROJECTION_ASSERT_SVH
`define VERTEX_SCREEN_PROJECTION_ASSERT_SVH

// same-cycle implication
`define VSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsp assertion failed");

// next-cycle implication
`define VSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsp assertion failed");

`endif

@@ rtl/vsp_pkg.sv @@
// shared constants, types and helpers for the vertex screen projection
// no dependencies
package vsp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SCREEN_BITS = 16;
    localparam int COORD_W     = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int CLIP_W      = PROD_W - FRAC_BITS + 2;
    localparam int NUM_W       = CLIP_W + 1;
    localparam int SIZE_W      = 14;
    localparam int P_W         = NUM_W + SIZE_W;
    localparam int DW          = P_W + SCREEN_BITS + 1;
    localparam int OUT_W       = 16;
    localparam int LANES       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 64;

    localparam logic [CFG_IDX_W-1:0] REG_XROW_XY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XROW_ZT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YROW_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YROW_ZT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WROW_XY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WROW_ZT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_W  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_H  = 3'd7;

    localparam logic [SIZE_W-1:0] VIEW_W_RST = 14'd640;
    localparam logic [SIZE_W-1:0] VIEW_H_RST = 14'd480;

    typedef logic signed [COORD_W-1:0] coef_t;

    typedef struct packed {
        coef_t cx;
        coef_t cy;
        coef_t cz;
        coef_t ct;
    } row_t;

    typedef struct packed {
        logic valid;
        logic vis;
    } ctl_t;

    function automatic logic signed [PROD_W-1:0] mul(coef_t a, coef_t b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return p;
    endfunction

endpackage

@@ rtl/vsp_dot.sv @@
// clip coordinate stages: products, then floor shift and row sums
// depends on vsp_pkg
module vsp_dot (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  vsp_pkg::coef_t                    point_x,
    input  vsp_pkg::coef_t                    point_y,
    input  vsp_pkg::coef_t                    point_z,
    input  vsp_pkg::row_t                     xrow,
    input  vsp_pkg::row_t                     yrow,
    input  vsp_pkg::row_t                     wrow,
    output logic                              valid_out,
    output logic signed [vsp_pkg::CLIP_W-1:0] cx,
    output logic signed [vsp_pkg::CLIP_W-1:0] cy,
    output logic signed [vsp_pkg::CLIP_W-1:0] cw
);

    vsp_pkg::row_t rows [3];
    logic signed [vsp_pkg::PROD_W-1:0] prod_reg [9];
    logic signed [vsp_pkg::PROD_W-1:0] prod_next [9];
    logic signed [vsp_pkg::CLIP_W-1:0] sum_reg [3];
    logic signed [vsp_pkg::CLIP_W-1:0] sum_next [3];
    logic v1_reg;
    logic v2_reg;

    assign rows[0] = xrow;
    assign rows[1] = yrow;
    assign rows[2] = wrow;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_next[3*r]   = vsp_pkg::mul(rows[r].cx, point_x);
            prod_next[3*r+1] = vsp_pkg::mul(rows[r].cy, point_y);
            prod_next[3*r+2] = vsp_pkg::mul(rows[r].cz, point_z);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = vsp_pkg::CLIP_W'(prod_reg[3*r] >>> vsp_pkg::FRAC_BITS)
                        + vsp_pkg::CLIP_W'(prod_reg[3*r+1] >>> vsp_pkg::FRAC_BITS)
                        + vsp_pkg::CLIP_W'(prod_reg[3*r+2] >>> vsp_pkg::FRAC_BITS)
                        + vsp_pkg::CLIP_W'(rows[r].ct);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign valid_out = v2_reg;
    assign cx = sum_reg[0];
    assign cy = sum_reg[1];
    assign cw = sum_reg[2];

endmodule

@@ rtl/vsp_div.sv @@
// viewport divide: overflow check, one quotient bit per stage, saturation
// depends on vsp_pkg
module vsp_div (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  vsp_pkg::ctl_t                                         ctl_in,
    input  logic [vsp_pkg::LANES-1:0][vsp_pkg::P_W-1:0]           prod,
    input  logic [vsp_pkg::LANES-1:0]                             neg,
    input  logic [vsp_pkg::NUM_W-1:0]                             dvs,
    output vsp_pkg::ctl_t                                         ctl_out,
    output logic [vsp_pkg::LANES-1:0][vsp_pkg::SCREEN_BITS-1:0]   res
);

    localparam int SB = vsp_pkg::SCREEN_BITS;
    localparam int L  = vsp_pkg::LANES;
    localparam logic [SB-1:0] HALF = SB'(1) << (SB - 1);
    localparam logic [SB-1:0] MAXV = HALF - SB'(1);

    vsp_pkg::ctl_t ctl_reg [SB+1];
    logic [vsp_pkg::NUM_W-1:0] d_reg [SB+1];
    logic [vsp_pkg::P_W-1:0] rem_reg [SB+1][L];
    logic [SB-1:0] q_reg [SB+1][L];
    logic ovf_reg [SB+1][L];
    logic neg_reg [SB+1][L];
    logic [L-1:0][SB-1:0] res_reg;
    logic [L-1:0][SB-1:0] res_next;
    vsp_pkg::ctl_t ctl_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SB; k++)
            begin
                ctl_reg[k] <= '0;
            end
            ctl_out_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k <= SB; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            ctl_out_reg <= ctl_reg[SB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= dvs;
            for (int l = 0; l < L; l++)
            begin
                rem_reg[0][l] <= prod[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg[l];
                ovf_reg[0][l] <= vsp_pkg::DW'(prod[l]) >= (vsp_pkg::DW'(dvs) << SB);
            end
        end
    end

    for (genvar k = 1; k <= SB; k++)
    begin : g_step
        localparam int SH = SB - k;
        logic [vsp_pkg::DW-1:0] trial [L];

        always_comb
        begin
            for (int l = 0; l < L; l++)
            begin
                trial[l] = vsp_pkg::DW'(rem_reg[k-1][l])
                         - (vsp_pkg::DW'(d_reg[k-1]) << SH);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_reg[k-1];
                for (int l = 0; l < L; l++)
                begin
                    rem_reg[k][l] <= trial[l][vsp_pkg::DW-1] ? rem_reg[k-1][l]
                                                             : vsp_pkg::P_W'(trial[l]);
                    q_reg[k][l]   <= {q_reg[k-1][l][SB-2:0], ~trial[l][vsp_pkg::DW-1]};
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            if (!ctl_reg[SB].vis)
            begin
                res_next[l] = '0;
            end
            else if (neg_reg[SB][l])
            begin
                res_next[l] = (ovf_reg[SB][l] || q_reg[SB][l] > HALF) ? HALF
                                                                      : SB'(0) - q_reg[SB][l];
            end
            else
            begin
                res_next[l] = (ovf_reg[SB][l] || q_reg[SB][l] > MAXV) ? MAXV
                                                                      : q_reg[SB][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign ctl_out = ctl_out_reg;
    assign res = res_reg;

endmodule

@@ rtl/vertex_screen_projection.sv @@
// vertex screen projection top level: config registers, clip to numerator stages
// depends on vsp_pkg, vsp_dot, vsp_div
//
// usage:
// - input channel in_valid/in_ready carries one point word (point_x/y/z, Q16.16)
// - output channel out_valid/out_ready carries screen_x, screen_y, visible
// - config channel cfg_valid/cfg_ready writes cfg_data to register cfg_index;
//   cfg_ready is always high, write only while no word is in flight
// - one point word per cycle sustained while the output is not stalled; from accept to
//   out_valid a word passes 2 dot product stages, 2 numerator stages, an overflow check,
//   16 quotient bit stages (one per screen bit) and the saturation register
// - the whole pipeline advances together; when out_valid is high and
//   out_ready is low everything holds and in_ready drops, nothing is lost
// - reset clears all valid bits and loads row registers with 0,
//   viewport size with 640 x 480
// - clip w <= 0 gives visible low with screen 0,0
module vertex_screen_projection (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [31:0]              point_x,
    input  logic signed [31:0]              point_y,
    input  logic signed [31:0]              point_z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              screen_x,
    output logic signed [15:0]              screen_y,
    output logic                            visible,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsp_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NW = vsp_pkg::NUM_W;
    localparam int L  = vsp_pkg::LANES;

    logic [vsp_pkg::CFG_W-1:0] xrow_xy_reg, xrow_zt_reg, yrow_xy_reg, yrow_zt_reg;
    logic [vsp_pkg::CFG_W-1:0] wrow_xy_reg, wrow_zt_reg;
    logic [vsp_pkg::SIZE_W-1:0] view_w_reg, view_h_reg;
    vsp_pkg::row_t xrow, yrow, wrow;
    logic en;
    logic dot_valid;
    logic signed [vsp_pkg::CLIP_W-1:0] cx, cy, cw;

    vsp_pkg::ctl_t c3_reg, c4_reg, ctl_out;
    logic signed [NW-1:0] n_reg [L];
    logic signed [vsp_pkg::CLIP_W-1:0] w_reg;
    logic [L-1:0][vsp_pkg::P_W-1:0] prod_reg;
    logic [L-1:0] neg_reg;
    logic [NW-1:0] d_reg;
    logic [NW-1:0] mag [L];
    logic [vsp_pkg::SIZE_W-1:0] size [L];
    logic [L-1:0][vsp_pkg::SCREEN_BITS-1:0] res;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xrow_xy_reg <= '0;
            xrow_zt_reg <= '0;
            yrow_xy_reg <= '0;
            yrow_zt_reg <= '0;
            wrow_xy_reg <= '0;
            wrow_zt_reg <= '0;
            view_w_reg  <= vsp_pkg::VIEW_W_RST;
            view_h_reg  <= vsp_pkg::VIEW_H_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vsp_pkg::REG_XROW_XY: xrow_xy_reg <= cfg_data;
                vsp_pkg::REG_XROW_ZT: xrow_zt_reg <= cfg_data;
                vsp_pkg::REG_YROW_XY: yrow_xy_reg <= cfg_data;
                vsp_pkg::REG_YROW_ZT: yrow_zt_reg <= cfg_data;
                vsp_pkg::REG_WROW_XY: wrow_xy_reg <= cfg_data;
                vsp_pkg::REG_WROW_ZT: wrow_zt_reg <= cfg_data;
                vsp_pkg::REG_VIEW_W:  view_w_reg  <= cfg_data[vsp_pkg::SIZE_W-1:0];
                vsp_pkg::REG_VIEW_H:  view_h_reg  <= cfg_data[vsp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign xrow = {xrow_xy_reg[31:0], xrow_xy_reg[63:32], xrow_zt_reg[31:0], xrow_zt_reg[63:32]};
    assign yrow = {yrow_xy_reg[31:0], yrow_xy_reg[63:32], yrow_zt_reg[31:0], yrow_zt_reg[63:32]};
    assign wrow = {wrow_xy_reg[31:0], wrow_xy_reg[63:32], wrow_zt_reg[31:0], wrow_zt_reg[63:32]};

    vsp_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .xrow      (xrow),
        .yrow      (yrow),
        .wrow      (wrow),
        .valid_out (dot_valid),
        .cx        (cx),
        .cy        (cy),
        .cw        (cw)
    );

    // numerator c + w, then magnitude times viewport size
    assign size[0] = view_w_reg;
    assign size[1] = view_h_reg;

    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            mag[l] = n_reg[l][NW-1] ? NW'(0) - NW'(n_reg[l]) : NW'(n_reg[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (en)
        begin
            c3_reg <= '{valid: dot_valid, vis: cw > 0};
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= NW'(cx) + NW'(cw);
            n_reg[1] <= NW'(cy) + NW'(cw);
            w_reg    <= cw;
            d_reg    <= NW'(w_reg) << 1;
            for (int l = 0; l < L; l++)
            begin
                prod_reg[l] <= vsp_pkg::P_W'(mag[l]) * vsp_pkg::P_W'(size[l]);
                neg_reg[l]  <= n_reg[l][NW-1];
            end
        end
    end

    vsp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (c4_reg),
        .prod    (prod_reg),
        .neg     (neg_reg),
        .dvs     (d_reg),
        .ctl_out (ctl_out),
        .res     (res)
    );

    assign out_valid = ctl_out.valid;
    assign visible   = ctl_out.vis;
    assign screen_x  = vsp_pkg::OUT_W'($signed(res[0]));
    assign screen_y  = vsp_pkg::OUT_W'($signed(res[1]));

endmodule

@@ rtl/vsp_checker.sv @@
// port level checks for the vertex screen projection, bound to the top level
// depends on vertex_screen_projection_assert.svh and vsp_pkg
`include "vertex_screen_projection_assert.svh"

module vsp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic signed [31:0]              point_x,
    input logic signed [31:0]              point_y,
    input logic signed [31:0]              point_z,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [15:0]              screen_x,
    input logic signed [15:0]              screen_y,
    input logic                            visible,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [vsp_pkg::CFG_W-1:0]       cfg_data
);

    // hidden word shows origin
    `VSP_ASSERT_IMP(a_hidden_zero, out_valid && !visible, screen_x == 0 && screen_y == 0)
    // a stalled output word blocks new input words
    `VSP_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)
    // config writes never wait
    `VSP_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
    // stalled output word holds
    `VSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(screen_x) && $stable(screen_y) && $stable(visible))

endmodule

bind vertex_screen_projection vsp_checker u_vsp_checker (.*);
